[rtl/mrll_pkg.sv]
// ----------------------------------------------------------------------------
// mrll_pkg: shared types and constants for the mesh route link lister
// Widths, register indexes, controller commands and the size clamp helper.
// ----------------------------------------------------------------------------
package mrll_pkg;

  localparam int MAX_DIM_SIZE = 16;

  // Fixed field widths
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int NODE_W    = 12;
  localparam int LINK_W    = 14;
  localparam int AXIS_W    = 2;

  // Widths that follow from the largest mesh dimension
  localparam int DIM_W   = $clog2(MAX_DIM_SIZE + 1);
  localparam int COORD_W = $clog2(MAX_DIM_SIZE);
  localparam int PLANE_W = $clog2(MAX_DIM_SIZE * MAX_DIM_SIZE + 1);
  localparam int TOTAL_W = $clog2(MAX_DIM_SIZE * MAX_DIM_SIZE * MAX_DIM_SIZE + 1);
  localparam int CMP_W   = (NODE_W > TOTAL_W) ? NODE_W : TOTAL_W;
  localparam int SHW     = (NODE_W > PLANE_W + COORD_W) ? NODE_W : PLANE_W + COORD_W;
  localparam int BIT_W   = (COORD_W > 1) ? $clog2(COORD_W) : 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = CFG_IDX_W'(2);

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic [CFG_W-1:0] x;
    logic [CFG_W-1:0] y;
    logic [CFG_W-1:0] z;
  } sizes_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_MUL2,
    OP_DIV,
    OP_PREP1,
    OP_PREP2,
    OP_HOP,
    OP_SINGLE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             div_y;
    logic [BIT_W-1:0] div_bit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic same;
    logic last;
  } status_t;

  // Clamp a size register into 1..MAX_DIM_SIZE
  function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM_SIZE) begin
      r = DIM_W'(MAX_DIM_SIZE);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/mrll_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mrll_cfg_regs: mesh size registers
// Holds x, y and z sizes; writes land whenever the write channel fires.
// ----------------------------------------------------------------------------
module mrll_cfg_regs import mrll_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output sizes_t               sizes
);

  logic wr;

  // Always take writes
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Update the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      sizes.x <= SIZE_RESET;
      sizes.y <= SIZE_RESET;
      sizes.z <= SIZE_RESET;
    end else if (wr) begin
      if (cfg_index == REG_X_SIZE) sizes.x <= cfg_data;
      if (cfg_index == REG_Y_SIZE) sizes.y <= cfg_data;
      if (cfg_index == REG_Z_SIZE) sizes.z <= cfg_data;
    end
  end

endmodule

[rtl/mrll_ctrl.sv]
// ----------------------------------------------------------------------------
// mrll_ctrl: route sequencer
// Steps the datapath through load, size products, checks, coordinate
// division, start-link setup and one hop per free output slot, or a single result.
// ----------------------------------------------------------------------------
module mrll_ctrl import mrll_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_CHECK,
    S_DIV,
    S_PREP1,
    S_PREP2,
    S_HOP,
    S_SINGLE
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             div_y;
  logic             div_y_next;
  logic [BIT_W-1:0] div_bit;
  logic [BIT_W-1:0] div_bit_next;
  logic             out_valid_next;
  logic             out_free;
  logic             emit;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and command
  always_comb begin
    state_next   = state;
    div_y_next   = div_y;
    div_bit_next = div_bit;
    cmd.op       = OP_NONE;
    cmd.div_y    = div_y;
    cmd.div_bit  = div_bit;
    emit         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op       = OP_MUL2;
        div_y_next   = 1'b0;
        div_bit_next = BIT_W'(COORD_W - 1);
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (status.bad || status.same) state_next = S_SINGLE;
        else state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (div_bit == '0) begin
          if (div_y) begin
            state_next = S_PREP1;
          end else begin
            div_y_next   = 1'b1;
            div_bit_next = BIT_W'(COORD_W - 1);
          end
        end else begin
          div_bit_next = div_bit - 1'b1;
        end
      end
      S_PREP1: begin
        cmd.op     = OP_PREP1;
        state_next = S_PREP2;
      end
      S_PREP2: begin
        cmd.op     = OP_PREP2;
        state_next = S_HOP;
      end
      S_HOP: begin
        if (out_free) begin
          cmd.op = OP_HOP;
          emit   = 1'b1;
          if (status.last) state_next = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          cmd.op     = OP_SINGLE;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Hold the result until taken, refill on emit
    if (emit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_y     <= 1'b0;
      div_bit   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_y     <= div_y_next;
      div_bit   <= div_bit_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/mrll_datapath.sv]
// ----------------------------------------------------------------------------
// mrll_datapath: coordinate split, link arithmetic and result register
// Restoring division recovers z and y one quotient bit per command; start
// links are built over the setup stages and then stepped by stride.
// ----------------------------------------------------------------------------
module mrll_datapath import mrll_pkg::*; (
  input  logic              clk,
  input  logic [NODE_W-1:0] source_node,
  input  logic [NODE_W-1:0] dest_node,
  input  sizes_t            sizes,
  input  cmd_t              cmd,
  output status_t           status,
  output logic [LINK_W-1:0] link_number,
  output logic [AXIS_W-1:0] link_axis,
  output logic              is_last,
  output logic              empty_route,
  output logic              bad_node
);

  logic [NODE_W-1:0]  src, dst;
  logic [DIM_W-1:0]   nx, ny, nz;
  logic [PLANE_W-1:0] plane, nzx, nzy;
  logic [TOTAL_W-1:0] total;
  logic [NODE_W-1:0]  rem_s, rem_d;
  logic [COORD_W-1:0] zq_s, yq_s, zq_d, yq_d;
  logic [COORD_W-1:0] cnt_x, cnt_y, cnt_z;
  logic [COORD_W-1:0] lo_x, x1;
  logic [PLANE_W-1:0] ax, ay, pz;
  logic [TOTAL_W-1:0] qz;
  logic [LINK_W-1:0]  start_x, start_y, start_z;

  // Division step
  logic [SHW-1:0]     div_base, div_shift;
  logic               ge_s, ge_d;

  // Coordinate views
  logic [COORD_W-1:0] x0c, x1c, y0c, y1c, z0c, z1c;
  logic [COORD_W-1:0] lo_y, lo_z;

  // Link arithmetic operands
  logic [LINK_W-1:0]  l_total, l_plane, l_nzx, l_nzy, l_x1, l_nx;

  logic               last_x, last_y, last_z;

  assign div_base  = cmd.div_y ? SHW'(nx) : SHW'(plane);
  assign div_shift = div_base << cmd.div_bit;
  assign ge_s      = SHW'(rem_s) >= div_shift;
  assign ge_d      = SHW'(rem_d) >= div_shift;

  assign x0c = rem_s[COORD_W-1:0];
  assign x1c = rem_d[COORD_W-1:0];
  assign y0c = yq_s;
  assign y1c = yq_d;
  assign z0c = zq_s;
  assign z1c = zq_d;
  assign lo_y = (y0c < y1c) ? y0c : y1c;
  assign lo_z = (z0c < z1c) ? z0c : z1c;

  assign l_total = LINK_W'(total);
  assign l_plane = LINK_W'(plane);
  assign l_nzx   = LINK_W'(nzx);
  assign l_nzy   = LINK_W'(nzy);
  assign l_x1    = LINK_W'(x1);
  assign l_nx    = LINK_W'(nx);

  // Status back to the sequencer
  assign status.bad  = (CMP_W'(src) >= CMP_W'(total)) || (CMP_W'(dst) >= CMP_W'(total));
  assign status.same = (src == dst);
  assign last_x = (cnt_x == COORD_W'(1)) && (cnt_y == '0) && (cnt_z == '0);
  assign last_y = (cnt_x == '0) && (cnt_y == COORD_W'(1)) && (cnt_z == '0);
  assign last_z = (cnt_x == '0) && (cnt_y == '0) && (cnt_z == COORD_W'(1));
  assign status.last = last_x || last_y || last_z;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      // Capture the item and clamp the sizes
      OP_LOAD: begin
        src <= source_node;
        dst <= dest_node;
        nx  <= eff_size(sizes.x);
        ny  <= eff_size(sizes.y);
        nz  <= eff_size(sizes.z);
      end
      // Plane and side-face products
      OP_MUL1: begin
        plane <= PLANE_W'(nx) * PLANE_W'(ny);
        nzx   <= PLANE_W'(nz) * PLANE_W'(nx);
        nzy   <= PLANE_W'(nz) * PLANE_W'(ny);
      end
      // Node count, seed the dividers
      OP_MUL2: begin
        total <= TOTAL_W'(plane) * TOTAL_W'(nz);
        rem_s <= src;
        rem_d <= dst;
        zq_s  <= '0;
        yq_s  <= '0;
        zq_d  <= '0;
        yq_d  <= '0;
      end
      // One quotient bit for both nodes
      OP_DIV: begin
        if (ge_s) begin
          rem_s <= rem_s - NODE_W'(div_shift);
          if (cmd.div_y) yq_s[cmd.div_bit] <= 1'b1;
          else zq_s[cmd.div_bit] <= 1'b1;
        end
        if (ge_d) begin
          rem_d <= rem_d - NODE_W'(div_shift);
          if (cmd.div_y) yq_d[cmd.div_bit] <= 1'b1;
          else zq_d[cmd.div_bit] <= 1'b1;
        end
      end
      // Hop counts and first-level products
      OP_PREP1: begin
        lo_x  <= (x0c < x1c) ? x0c : x1c;
        x1    <= x1c;
        cnt_x <= (x0c < x1c) ? x1c - x0c : x0c - x1c;
        cnt_y <= (y0c < y1c) ? y1c - y0c : y0c - y1c;
        cnt_z <= (z0c < z1c) ? z1c - z0c : z0c - z1c;
        ax    <= PLANE_W'(y0c) + PLANE_W'(z0c) * PLANE_W'(ny);
        ay    <= PLANE_W'(lo_y) + PLANE_W'(z0c) * (PLANE_W'(ny) - PLANE_W'(1));
        pz    <= PLANE_W'(y1c) * PLANE_W'(nx);
        qz    <= TOTAL_W'(lo_z) * TOTAL_W'(plane);
      end
      // First link of each axis
      OP_PREP2: begin
        start_x <= LINK_W'(lo_x) + LINK_W'(ax) * (l_nx - LINK_W'(1));
        start_y <= (l_total - l_nzy) + l_x1 + l_nx * LINK_W'(ay);
        start_z <= (l_total - l_nzy) + (l_total - l_nzx) + l_x1
                   + LINK_W'(pz) + LINK_W'(qz);
      end
      // Emit the next link and advance along its axis
      OP_HOP: begin
        is_last     <= status.last;
        empty_route <= 1'b0;
        bad_node    <= 1'b0;
        if (cnt_x != '0) begin
          link_number <= start_x;
          link_axis   <= AXIS_X;
          start_x     <= start_x + LINK_W'(1);
          cnt_x       <= cnt_x - 1'b1;
        end else if (cnt_y != '0) begin
          link_number <= start_y;
          link_axis   <= AXIS_Y;
          start_y     <= start_y + l_nx;
          cnt_y       <= cnt_y - 1'b1;
        end else begin
          link_number <= start_z;
          link_axis   <= AXIS_Z;
          start_z     <= start_z + l_plane;
          cnt_z       <= cnt_z - 1'b1;
        end
      end
      // Lone result for a bad node or an empty route
      OP_SINGLE: begin
        link_number <= '0;
        link_axis   <= AXIS_X;
        is_last     <= 1'b1;
        empty_route <= !status.bad;
        bad_node    <= status.bad;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/mesh_route_link_list.sv]
// ----------------------------------------------------------------------------
// mesh_route_link_list: dimension-order route on a 3D mesh as link numbers
// Splits source and destination into coordinates and lists every link
// crossed going x, then y, then z.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  -----------------------------------------
//  input    in_valid / in_ready  source_node, dest_node
//  output   out_valid/out_ready  link_number, link_axis, is_last,
//                                empty_route, bad_node
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Sequence: each item is loaded, then come the size products, a check, the
//  restoring division steps for z and y, the start-link setup and one hop
//  per result while the output is free; a bad node or empty route goes from
//  the check straight to a single result.
//  Reset: synchronous; sizes return to 4, no result pending.
//  Stalls: the result register holds while out_ready is low and the hop
//  sequence waits; in_ready is high only between items.
//
module mesh_route_link_list import mrll_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NODE_W-1:0]    source_node,
  input  logic [NODE_W-1:0]    dest_node,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LINK_W-1:0]    link_number,
  output logic [AXIS_W-1:0]    link_axis,
  output logic                 is_last,
  output logic                 empty_route,
  output logic                 bad_node,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sizes_t  sizes;
  cmd_t    cmd;
  status_t status;

  mrll_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sizes     (sizes)
  );

  mrll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  mrll_datapath u_dp (
    .clk         (clk),
    .source_node (source_node),
    .dest_node   (dest_node),
    .sizes       (sizes),
    .cmd         (cmd),
    .status      (status),
    .link_number (link_number),
    .link_axis   (link_axis),
    .is_last     (is_last),
    .empty_route (empty_route),
    .bad_node    (bad_node)
  );

endmodule

[rtl/mrll_checker.sv]
// ----------------------------------------------------------------------------
// mrll_checker: port-level checks for the mesh route link lister
// Watches the top-level ports and flags broken result sequences.
// ----------------------------------------------------------------------------
module mrll_checker import mrll_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LINK_W-1:0]    link_number,
  input logic [AXIS_W-1:0]    link_axis,
  input logic                 is_last,
  input logic                 empty_route,
  input logic                 bad_node
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(link_number)
      && $stable(link_axis) && $stable(is_last))
    else $error("stalled item changed");

  // Bad or empty results close their sequence
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bad_node || empty_route) |-> is_last && link_number == '0)
    else $error("single result not marked last");

  // Never flag both bad node and empty route
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_node && empty_route))
    else $error("conflicting flags");

  // Busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took input while busy");

  // No new item while a route is unfinished
  a_mid_route: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> !in_ready)
    else $error("input open mid route");

endmodule

bind mesh_route_link_list mrll_checker u_mrll_checker (.*);
